/* hw/rtl/olist_pkg.sv */
package olist_pkg;

   localparam int LIST_DEPTH = 64;

   localparam int OP_W      = 3;
   localparam int POS_W     = 6;
   localparam int VAL_W     = 32;
   localparam int ST_W      = 3;
   localparam int CNT_OUT_W = 7;

   localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int GROUP_SIZE = 8;
   localparam int GROUP_W    = 3;
   localparam int NUM_GROUPS = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
   localparam logic [OP_W-1:0] OP_ERASE      = 3'd5;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd6;
   localparam logic [OP_W-1:0] OP_MODIFY     = 3'd7;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [ST_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

   localparam logic [1:0] CMD_HOLD  = 2'd0;
   localparam logic [1:0] CMD_UP    = 2'd1;
   localparam logic [1:0] CMD_DOWN  = 2'd2;
   localparam logic [1:0] CMD_WRITE = 2'd3;

   typedef struct packed {
      logic [1:0]              kind;
      logic [IDX_W-1:0]        at;
      logic signed [VAL_W-1:0] value;
      logic [CNT_W-1:0]        count;
   } cell_cmd_type;

endpackage

/* hw/rtl/olist_cell.sv */
module olist_cell
   import olist_pkg::*;
(
   input  logic                    clock,
   input  logic [IDX_W-1:0]        index,
   input  cell_cmd_type            cmd,
   input  logic signed [VAL_W-1:0] left_entry,
   input  logic signed [VAL_W-1:0] right_entry,
   output logic signed [VAL_W-1:0] entry,
   output logic                    match
);

   logic signed [VAL_W-1:0] entry_ff;
   logic signed [VAL_W-1:0] entry_in;
   logic                    match_ff;
   logic                    match_in;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.kind)
         CMD_HOLD: begin
            entry_in = entry_ff;
         end
         CMD_UP: begin
            if (index > cmd.at) begin
               entry_in = left_entry;
            end else if (index == cmd.at) begin
               entry_in = cmd.value;
            end
         end
         CMD_DOWN: begin
            if (index >= cmd.at) begin
               entry_in = right_entry;
            end
         end
         CMD_WRITE: begin
            if (index == cmd.at) begin
               entry_in = cmd.value;
            end
         end
      endcase
   end

   assign match_in = (entry_ff == cmd.value) && (CNT_W'(index) < cmd.count);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;
   assign match = match_ff;

endmodule

/* hw/rtl/olist_prio.sv */
module olist_prio
   import olist_pkg::*;
(
   input  logic                  clock,
   input  logic [LIST_DEPTH-1:0] match,
   output logic                  found,
   output logic [IDX_W-1:0]      found_index
);

   logic [PAD_W-1:0]   padded;
   logic               any_in [NUM_GROUPS];
   logic [GROUP_W-1:0] low_in [NUM_GROUPS];
   logic               any_ff [NUM_GROUPS];
   logic [GROUP_W-1:0] low_ff [NUM_GROUPS];

   assign padded = PAD_W'(match);

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         any_in[g] = |padded[g*GROUP_SIZE +: GROUP_SIZE];
         low_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (padded[g*GROUP_SIZE + j]) begin
               low_in[g] = GROUP_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         any_ff[g] <= any_in[g];
         low_ff[g] <= low_in[g];
      end
   end

   always_comb begin
      found       = 1'b0;
      found_index = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            found       = 1'b1;
            found_index = IDX_W'(g * GROUP_SIZE) + IDX_W'(low_ff[g]);
         end
      end
   end

endmodule

/* hw/rtl/ordered_list_engine_core.sv */
// Each operation but find is registered in the pending and then the response register; find
// first passes the cell compare, the group encoder and the group select. One item per cycle
// for all operations but find while the response side does not stall; a find holds off new
// requests until its result is pending. Items that move or write entries update the whole row
// of entry cells in the cycle they are accepted. Reset is synchronous and clears the count,
// the sequencer and the result valid flags; the stored entries are not cleared.
module ordered_list_engine_core
   import olist_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // position[5:0], value[37:6], zero[39:38]
   input  logic [2:0]  req_tuser,  // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // found_index[5:0], entry_count[12:6], zero[15:13]
   output logic [2:0]  rsp_tuser   // status[2:0]
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ENC1 = 2'd1;
   localparam logic [1:0] S_ENC2 = 2'd2;

   logic [1:0]              state_ff;
   logic [1:0]              state_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    pend_valid_ff;
   logic                    pend_valid_in;
   logic [ST_W-1:0]         pend_status_ff;
   logic [ST_W-1:0]         pend_status_in;
   logic [POS_W-1:0]        pend_index_ff;
   logic [POS_W-1:0]        pend_index_in;
   logic [CNT_OUT_W-1:0]    pend_count_ff;
   logic [CNT_OUT_W-1:0]    pend_count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [ST_W-1:0]         rsp_status_ff;
   logic [POS_W-1:0]        rsp_index_ff;
   logic [CNT_OUT_W-1:0]    rsp_count_ff;

   logic [OP_W-1:0]         operation;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;
   logic                    req_accept;
   logic                    out_free;
   logic                    write_pend;
   logic                    full;
   logic                    empty;
   logic                    bad_pos;
   logic [1:0]              op_kind;
   logic [IDX_W-1:0]        op_at;
   logic [ST_W-1:0]         op_status;
   logic [CNT_W-1:0]        op_count;
   cell_cmd_type            cmd;

   logic signed [VAL_W-1:0] entry_w [LIST_DEPTH];
   logic [LIST_DEPTH-1:0]   match_w;
   logic                    prio_found;
   logic [IDX_W-1:0]        prio_index;

   assign operation = req_tuser;
   assign position  = req_tdata[5:0];
   assign value     = $signed(req_tdata[37:6]);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && (!pend_valid_ff || out_free);
   assign req_accept = req_tvalid && req_tready;

   assign full    = (count_ff == CNT_W'(LIST_DEPTH));
   assign empty   = (count_ff == '0);
   assign bad_pos = (CMP_W'(position) >= CMP_W'(count_ff));

   always_comb begin
      op_kind   = CMD_HOLD;
      op_at     = IDX_W'(position);
      op_status = ST_OK;
      op_count  = count_ff;
      unique case (operation)
         OP_PUSH_BACK: begin
            if (full) begin
               op_status = ST_FULL;
            end else begin
               op_kind  = CMD_WRITE;
               op_at    = IDX_W'(count_ff);
               op_count = count_ff + 1'b1;
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               op_status = ST_FULL;
            end else begin
               op_kind  = CMD_UP;
               op_at    = '0;
               op_count = count_ff + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               op_status = ST_EMPTY;
            end else begin
               op_count = count_ff - 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               op_status = ST_EMPTY;
            end else begin
               op_kind  = CMD_DOWN;
               op_at    = '0;
               op_count = count_ff - 1'b1;
            end
         end
         OP_INSERT: begin
            if (bad_pos) begin
               op_status = ST_BADPOS;
            end else if (full) begin
               op_status = ST_FULL;
            end else begin
               op_kind  = CMD_UP;
               op_count = count_ff + 1'b1;
            end
         end
         OP_ERASE: begin
            if (bad_pos) begin
               op_status = ST_BADPOS;
            end else begin
               op_kind  = CMD_DOWN;
               op_count = count_ff - 1'b1;
            end
         end
         OP_FIND: begin
            op_status = ST_NOTFOUND;
         end
         OP_MODIFY: begin
            if (bad_pos) begin
               op_status = ST_BADPOS;
            end else begin
               op_kind = CMD_WRITE;
            end
         end
      endcase
   end

   always_comb begin
      cmd.kind  = req_accept ? op_kind : CMD_HOLD;
      cmd.at    = op_at;
      cmd.value = value;
      cmd.count = count_ff;
   end

   genvar i;
   generate
      for (i = 0; i < LIST_DEPTH; i++) begin : g_cell
         logic signed [VAL_W-1:0] left_w;
         logic signed [VAL_W-1:0] right_w;

         if (i == 0) begin : g_first
            assign left_w = value;
         end else begin : g_inner_left
            assign left_w = entry_w[i-1];
         end

         if (i == LIST_DEPTH - 1) begin : g_last
            assign right_w = entry_w[i];
         end else begin : g_inner_right
            assign right_w = entry_w[i+1];
         end

         olist_cell u_cell (
            .clock       (clock),
            .index       (IDX_W'(i)),
            .cmd         (cmd),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry_w[i]),
            .match       (match_w[i])
         );
      end
   endgenerate

   olist_prio u_prio (
      .clock       (clock),
      .match       (match_w),
      .found       (prio_found),
      .found_index (prio_index)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      write_pend     = 1'b0;
      pend_status_in = op_status;
      pend_index_in  = '0;
      pend_count_in  = CNT_OUT_W'(op_count);
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               count_in = op_count;
               if (operation == OP_FIND) begin
                  state_in = S_ENC1;
               end else begin
                  write_pend = 1'b1;
               end
            end
         end
         S_ENC1: begin
            state_in = S_ENC2;
         end
         S_ENC2: begin
            state_in       = S_IDLE;
            write_pend     = 1'b1;
            pend_status_in = prio_found ? ST_OK : ST_NOTFOUND;
            pend_index_in  = prio_found ? POS_W'(prio_index) : '0;
            pend_count_in  = CNT_OUT_W'(count_ff);
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (write_pend) begin
         pend_valid_in = 1'b1;
      end else if (out_free) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
      rsp_valid_in = out_free ? pend_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_pend) begin
         pend_status_ff <= pend_status_in;
         pend_index_ff  <= pend_index_in;
         pend_count_ff  <= pend_count_in;
      end
      if (out_free && pend_valid_ff) begin
         rsp_status_ff <= pend_status_ff;
         rsp_index_ff  <= pend_index_ff;
         rsp_count_ff  <= pend_count_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
